@@ rtl/core/cohdir_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cohdir_pkg;

   localparam int ADDR_BITS   = 48;
   localparam int LINE_BYTES  = 64;
   localparam int DIR_ENTRIES = 1024;
   localparam int NUM_CPUS    = 32;

   localparam int OFFSET_BITS  = $clog2(LINE_BYTES);
   localparam int IDX_BITS     = $clog2(DIR_ENTRIES);
   localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - IDX_BITS;
   localparam int CPU_SEL_BITS = $clog2(NUM_CPUS);
   localparam int STATES_W     = 2 * NUM_CPUS;
   localparam int WORD_W       = 1 + TAG_BITS + STATES_W;

   localparam int OP_W    = 3;
   localparam int BADDR_W = 48;
   localparam int CPU_W   = 6;
   localparam int RSTATE_W = 3;

   localparam int OP_LSB    = 0;
   localparam int BADDR_LSB = OP_LSB + OP_W;
   localparam int CPU_LSB   = BADDR_LSB + BADDR_W;
   localparam int RSTATE_LSB = CPU_LSB + CPU_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [2:0] {
      OP_READ       = 3'd0,
      OP_WRITE      = 3'd1,
      OP_UPGRADE    = 3'd2,
      OP_DOWNGRADE  = 3'd3,
      OP_INVALIDATE = 3'd4,
      OP_FLUSH      = 3'd5,
      OP_BROADCAST  = 3'd6,
      OP_SNOOP      = 3'd7
   } op_type;

   localparam logic [1:0] ST_I = 2'd0;
   localparam logic [1:0] ST_S = 2'd1;
   localparam logic [1:0] ST_M = 2'd2;
   localparam logic [1:0] ST_E = 2'd3;

   localparam logic [1:0] PROTO_NONE  = 2'd0;
   localparam logic [1:0] PROTO_MSI   = 2'd1;
   localparam logic [1:0] PROTO_MESI  = 2'd2;
   localparam logic [1:0] PROTO_MOESI = 2'd3;

   typedef logic [NUM_CPUS-1:0][1:0] cpu_st_type;

   typedef struct packed {
      logic                load;
      logic                commit;
      logic                clear_wr;
      logic [IDX_BITS-1:0] clear_addr;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/core/cohdir_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cohdir_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output cohdir_pkg::cmd_type    cmd
);
   import cohdir_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                commit;
   logic                load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign load       = req_tvalid && (state_ff == S_IDLE);
   assign commit     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign cmd.load       = load;
   assign cmd.commit     = commit;
   assign cmd.clear_wr   = (state_ff == S_CLEAR);
   assign cmd.clear_addr = clr_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + IDX_BITS'(1);
            if (clr_cnt_ff == IDX_BITS'(DIR_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/cohdir_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cohdir_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cohdir_pkg::cmd_type                 cmd,
   input  wire logic [cohdir_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic [cohdir_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [1:0]                          csr_wr_data
);
   import cohdir_pkg::*;

   logic [WORD_W-1:0]   dir_mem [DIR_ENTRIES];
   logic [WORD_W-1:0]   rd_word_ff;
   logic [1:0]          protocol_ff;
   op_type              op_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic [CPU_W-1:0]    cpu_ff;
   logic [RSTATE_W-1:0] rstate_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [BADDR_W-1:0]  in_addr;
   logic [IDX_BITS-1:0] in_idx;
   logic [TAG_BITS-1:0] in_tag;

   logic                old_valid;
   logic [TAG_BITS-1:0] old_tag;
   cpu_st_type          old_states;
   cpu_st_type          base;
   cpu_st_type          new_states;
   logic                hit;
   logic                uses_cpu;
   logic                uses_req;
   logic                err;
   logic                alloc;
   logic                others;
   logic [CPU_SEL_BITS-1:0] csel;
   logic [1:0]          cur;
   logic [1:0]          req2;
   logic [1:0]          line_state;
   logic [WORD_W-1:0]   new_word;

   assign in_addr = req_tdata[BADDR_LSB +: BADDR_W];
   assign in_idx  = in_addr[OFFSET_BITS +: IDX_BITS];
   assign in_tag  = in_addr[OFFSET_BITS + IDX_BITS +: TAG_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= PROTO_MESI;
      end else if (csr_wr_en) begin
         protocol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_tdata[OP_LSB +: OP_W]);
         tag_ff     <= in_tag;
         idx_ff     <= in_idx;
         cpu_ff     <= req_tdata[CPU_LSB +: CPU_W];
         rstate_ff  <= req_tdata[RSTATE_LSB +: RSTATE_W];
         rd_word_ff <= dir_mem[in_idx];
      end
      if (cmd.commit) begin
         rsp_data_ff <= {4'b0000, hit && !err, line_state, err};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         dir_mem[cmd.clear_addr] <= '0;
      end else if (cmd.commit && !err) begin
         dir_mem[idx_ff] <= new_word;
      end
   end

   always_comb begin
      old_valid  = rd_word_ff[WORD_W-1];
      old_tag    = rd_word_ff[STATES_W +: TAG_BITS];
      old_states = cpu_st_type'(rd_word_ff[STATES_W-1:0]);
      hit        = old_valid && (old_tag == tag_ff);
      uses_cpu   = (op_ff == OP_READ) || (op_ff == OP_WRITE) || (op_ff == OP_UPGRADE)
                   || (op_ff == OP_DOWNGRADE) || (op_ff == OP_SNOOP);
      uses_req   = (op_ff == OP_UPGRADE) || (op_ff == OP_DOWNGRADE);
      err        = (uses_cpu && (cpu_ff >= CPU_W'(NUM_CPUS)))
                   || (uses_req && (rstate_ff > RSTATE_W'(3)));
      alloc      = ((op_ff == OP_READ) || (op_ff == OP_WRITE) || (op_ff == OP_UPGRADE)) && !hit;
      base       = alloc ? '0 : old_states;
      csel       = cpu_ff[CPU_SEL_BITS-1:0];
      cur        = base[csel];
      req2       = rstate_ff[1:0];
      new_states = base;
      others     = 1'b0;
      line_state = ST_I;
      unique case (op_ff)
         OP_READ: begin
            if (protocol_ff == PROTO_NONE) begin
               new_states[csel] = ST_S;
            end else if (cur == ST_I) begin
               for (int i = 0; i < NUM_CPUS; i++) begin
                  if ((base[i] == ST_M) || ((protocol_ff != PROTO_MSI) && (base[i] == ST_E))) begin
                     new_states[i] = ST_S;
                     others = 1'b1;
                  end else if (base[i] != ST_I) begin
                     others = 1'b1;
                  end
               end
               new_states[csel] = ((protocol_ff == PROTO_MSI) || others) ? ST_S : ST_E;
            end
         end
         OP_WRITE: begin
            if (protocol_ff != PROTO_NONE) begin
               new_states = '0;
            end
            new_states[csel] = ST_M;
         end
         OP_UPGRADE: begin
            if (cur < req2) begin
               if (((protocol_ff != PROTO_NONE) && (req2 == ST_M))
                   || ((protocol_ff == PROTO_MESI) && (req2 == ST_E))) begin
                  new_states = '0;
               end
               new_states[csel] = req2;
            end
         end
         OP_DOWNGRADE: begin
            if (hit && (cur > req2)) begin
               new_states[csel] = req2;
            end
         end
         OP_INVALIDATE: begin
            if (hit) begin
               new_states = '0;
            end
         end
         OP_FLUSH: begin
            if (hit) begin
               for (int i = 0; i < NUM_CPUS; i++) begin
                  if (base[i] == ST_M) begin
                     new_states[i] = ST_S;
                  end
               end
            end
         end
         OP_BROADCAST: begin
            if (hit) begin
               for (int i = 0; i < NUM_CPUS; i++) begin
                  if (base[i] == ST_I) begin
                     new_states[i] = ST_S;
                  end
               end
            end
         end
         OP_SNOOP: begin
            if (hit && !err) begin
               line_state = cur;
            end
         end
      endcase
      if (err) begin
         line_state = ST_I;
      end
      new_word = {old_valid | alloc, alloc ? tag_ff : old_tag, STATES_W'(new_states)};
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/coherence_directory.sv @@
// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   req_tdata: op, byte_address, cpu, requested_state
// rsp       out  rsp_tvalid / rsp_tready   rsp_tdata: status, line_state, entry_hit
// csr       in   csr_wr_en                 csr_wr_data: protocol
//
// an item makes one directory memory read, then an update and write back
// the directory memory has a single port, so items are handled one at a time
// after reset a clearing pass over all 1024 entries runs before req_tready rises
// a waiting result holds in the output register; the next item is accepted meanwhile
// and stalls in its update cycle until rsp is free
`timescale 1ns / 1ps
`default_nettype none
module coherence_directory (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // op[2:0], byte_address[50:3], cpu[56:51], requested_state[59:57], zero fill
   input  wire logic [cohdir_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[0], line_state[2:1], entry_hit[3], zero fill
   output logic [cohdir_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [1:0]                        csr_wr_data
);
   import cohdir_pkg::*;

   cmd_type cmd;

   cohdir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cohdir_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous item in flight");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[3:1] == 3'b000))
      else $error("error response carries state or hit");

   a_state_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:1] != 2'b00)) |-> rsp_tdata[3])
      else $error("line state reported without hit");
`endif

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import cohdir_pkg::*;

   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [RSTATE_W-1:0] rstate;
      logic [CPU_W-1:0]    cpu;
      logic [BADDR_W-1:0]  baddr;
      op_type              op;
   } dir_req_t;

   typedef struct packed {
      logic       entry_hit;
      logic [1:0] line_state;
      logic       status;
   } dir_rsp_t;

   localparam logic [BADDR_W-1:0] LINE_A = 48'h0000_0001_017F;
   localparam logic [BADDR_W-1:0] LINE_C = 48'h0000_0002_0140;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [1:0]            csr_wr_data = '0;

   // directory mirror
   logic [1:0]          model_protocol = PROTO_MESI;
   bit                  dir_valid  [DIR_ENTRIES];
   logic [TAG_BITS-1:0] dir_tag    [DIR_ENTRIES];
   cpu_st_type          dir_states [DIR_ENTRIES];
   dir_rsp_t            dir_outcomes[$];

   int send_idle_pct;
   int rcv_idle_pct;
   int hold_orders;
   int hold_taken;
   int hold_left;
   int items_sent;
   int responses_seen;
   int errors;

   coherence_directory dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic dir_rsp_t directory_step(input dir_req_t r);
      logic [IDX_BITS-1:0] idx;
      logic [TAG_BITS-1:0] tg;
      logic                hit;
      logic                uses_cpu;
      logic                uses_req;
      logic                others;
      logic [1:0]          target;
      cpu_st_type          st;
      int                  c;
      dir_rsp_t            res;
      idx      = r.baddr[OFFSET_BITS +: IDX_BITS];
      tg       = r.baddr[OFFSET_BITS + IDX_BITS +: TAG_BITS];
      hit      = dir_valid[idx] && (dir_tag[idx] == tg);
      uses_cpu = (r.op <= OP_DOWNGRADE) || (r.op == OP_SNOOP);
      uses_req = (r.op == OP_UPGRADE) || (r.op == OP_DOWNGRADE);
      res      = '0;
      if ((uses_cpu && r.cpu >= NUM_CPUS) || (uses_req && r.rstate > 3)) begin
         res.status = 1'b1;
         return res;
      end
      c      = uses_cpu ? int'(r.cpu) : 0;
      target = r.rstate[1:0];
      st     = dir_states[idx];
      if (r.op <= OP_UPGRADE && !hit) begin
         dir_valid[idx] = 1'b1;
         dir_tag[idx]   = tg;
         st             = '0;
      end
      case (r.op)
         OP_READ: begin
            if (model_protocol == PROTO_NONE)
               st[c] = ST_S;
            else if (st[c] == ST_I) begin
               others = 1'b0;
               for (int i = 0; i < NUM_CPUS; i++) begin
                  if (st[i] == ST_M || (model_protocol != PROTO_MSI && st[i] == ST_E)) begin
                     st[i]  = ST_S;
                     others = 1'b1;
                  end else if (st[i] != ST_I)
                     others = 1'b1;
               end
               st[c] = (model_protocol == PROTO_MSI || others) ? ST_S : ST_E;
            end
         end
         OP_WRITE: begin
            if (model_protocol != PROTO_NONE)
               st = '0;
            st[c] = ST_M;
         end
         OP_UPGRADE: begin
            if (st[c] < target) begin
               if ((model_protocol != PROTO_NONE && target == ST_M) ||
                   (model_protocol == PROTO_MESI && target == ST_E))
                  st = '0;
               st[c] = target;
            end
         end
         OP_DOWNGRADE: begin
            if (hit && st[c] > target)
               st[c] = target;
         end
         OP_INVALIDATE: begin
            if (hit)
               st = '0;
         end
         OP_FLUSH: begin
            if (hit)
               for (int i = 0; i < NUM_CPUS; i++)
                  if (st[i] == ST_M)
                     st[i] = ST_S;
         end
         OP_BROADCAST: begin
            if (hit)
               for (int i = 0; i < NUM_CPUS; i++)
                  if (st[i] == ST_I)
                     st[i] = ST_S;
         end
         default: begin
            if (hit)
               res.line_state = st[c];
         end
      endcase
      dir_states[idx] = st;
      res.entry_hit   = hit;
      return res;
   endfunction

   function automatic dir_req_t build_req(input op_type op, input logic [BADDR_W-1:0] a,
                                          input logic [CPU_W-1:0] c,
                                          input logic [RSTATE_W-1:0] s);
      dir_req_t r;
      r.op     = op;
      r.baddr  = a;
      r.cpu    = c;
      r.rstate = s;
      return r;
   endfunction

   // a few hot lines with colliding tags, now and then any address at all
   function automatic logic [BADDR_W-1:0] pick_address();
      logic [63:0]         w;
      logic [TAG_BITS-1:0] tg;
      logic [IDX_BITS-1:0] ix;
      logic [5:0]          off;
      w   = {$urandom, $urandom};
      off = $urandom_range(63);
      ix  = $urandom_range(3) * 341;
      case ($urandom_range(2))
         0: tg = '0;
         1: tg = '1;
         default: tg = 1;
      endcase
      if ($urandom_range(7) == 0)
         return w[BADDR_W-1:0];
      return {tg, ix, off};
   endfunction

   function automatic dir_req_t random_request();
      dir_req_t r;
      r.op    = op_type'($urandom_range(7));
      r.baddr = pick_address();
      if ($urandom_range(9) == 0)
         r.cpu = $urandom_range(63);
      else if ($urandom_range(1) == 0)
         r.cpu = $urandom_range(3);
      else
         r.cpu = $urandom_range(NUM_CPUS - 1);
      r.rstate = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3);
      return r;
   endfunction

   task automatic send_item(input dir_req_t r);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - $bits(dir_req_t)){1'b0}}, r};
      do @(posedge clock); while (!req_tready);
      dir_outcomes.push_back(directory_step(r));
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (dir_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_protocol(input logic [1:0] p);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      model_protocol = p;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // runs under the reset protocol
   task automatic test_directed_cases();
      send_item(build_req(OP_SNOOP, '0, 6'd0, 3'd0));
      send_item(build_req(OP_READ, LINE_A, 6'd0, 3'd0));
      send_item(build_req(OP_READ, LINE_A, 6'd31, 3'd0));
      send_item(build_req(OP_READ, LINE_A, 6'd31, 3'd0));
      send_item(build_req(OP_WRITE, LINE_A, 6'd5, 3'd0));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd5, 3'd0));
      send_item(build_req(OP_FLUSH, LINE_A, 6'd40, 3'd7));
      send_item(build_req(OP_BROADCAST, LINE_A, 6'd63, 3'd5));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd17, 3'd0));
      send_item(build_req(OP_DOWNGRADE, LINE_A, 6'd5, ST_I));
      send_item(build_req(OP_UPGRADE, LINE_A, 6'd3, ST_M));
      send_item(build_req(OP_UPGRADE, LINE_A, 6'd3, ST_S));
      send_item(build_req(OP_UPGRADE, LINE_A, 6'd3, ST_E));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd3, 3'd0));
      send_item(build_req(OP_INVALIDATE, LINE_A, 6'd63, 3'd7));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd3, 3'd0));
      send_item(build_req(OP_READ, LINE_A, 6'd63, 3'd0));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd32, 3'd0));
      send_item(build_req(OP_UPGRADE, LINE_A, 6'd1, 3'd7));
      send_item(build_req(OP_DOWNGRADE, LINE_A, 6'd1, 3'd4));
      send_item(build_req(OP_DOWNGRADE, 48'h80, 6'd2, ST_I));
      send_item(build_req(OP_UPGRADE, 48'hFFFF_FFFF_FFFF, 6'd31, ST_S));
      send_item(build_req(OP_WRITE, LINE_C, 6'd0, 3'd0));
      send_item(build_req(OP_SNOOP, LINE_A, 6'd0, 3'd0));
   endtask

   task automatic test_random_traffic(input logic [1:0] p, input int count);
      set_protocol(p);
      repeat (count) send_item(random_request());
   endtask

   task automatic test_input_stall();
      int saved;
      saved         = send_idle_pct;
      send_idle_pct = 0;
      hold_orders++;
      repeat (40) send_item(random_request());
      send_idle_pct = saved;
      wait_idle();
   endtask

   always @(negedge clock) begin
      if (hold_orders != hold_taken) begin
         hold_taken <= hold_orders;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   function automatic void check_field(input string name, input logic [1:0] want,
                                       input logic [1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      dir_rsp_t got;
      dir_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[3:0];
         responses_seen++;
         if (dir_outcomes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = dir_outcomes.pop_front();
            check_field("status", want.status, got.status);
            check_field("line_state", want.line_state, got.line_state);
            check_field("entry_hit", want.entry_hit, got.entry_hit);
         end
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      rcv_idle_pct  = 78;
      test_directed_cases();
      test_random_traffic(PROTO_MOESI, 150);
      test_random_traffic(PROTO_NONE, 100);
      send_idle_pct = 78;
      rcv_idle_pct  = 16;
      test_random_traffic(PROTO_MSI, 150);
      test_input_stall();
      test_random_traffic(PROTO_MESI, 100);
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_random_traffic(PROTO_MOESI, 120);
      test_random_traffic(PROTO_NONE, 60);
      test_random_traffic(PROTO_MSI, 60);
      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered all ops, bad cpu and target cases, evictions and all four protocols");
      $display("%0d requests sent, %0d responses checked, %0d errors",
               items_sent, responses_seen, errors);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
